>>> rtl/kkh_pkg.sv
package kkh_pkg;

  // field and lane widths
  localparam int unsigned LaneW     = 16;
  localparam int unsigned VecW      = 3 * LaneW;
  localparam int unsigned InDataW   = 5 * VecW;
  localparam int unsigned ChanW     = 20;
  localparam int unsigned OutDataW  = 64;

  // defaults of the top level parameters
  localparam int unsigned VecFracBits = 14;
  localparam int unsigned SpecExp     = 20;
  localparam int unsigned ExpCntW     = 7;

  // shared multiplier operand and product widths
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // root and quotient units
  localparam int unsigned RootArgW = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned QuotW    = 17;

  localparam logic [QuotW-1:0] OneQ16   = 17'h10000;
  localparam logic [ChanW-1:0] ChanMax  = '1;
  localparam logic [ChanW-1:0] AmbRed   = 20'd0;
  localparam logic [ChanW-1:0] AmbGreen = 20'd102;
  localparam logic [ChanW-1:0] AmbBlue  = 20'd205;

  // lane and dot product codes
  localparam logic [1:0] LaneLast = 2'd2;
  localparam logic [1:0] OpLen    = 2'd0;
  localparam logic [1:0] OpDotL   = 2'd1;
  localparam logic [1:0] OpDotV   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_LEN_GO,
    ST_LEN_WAIT,
    ST_DIVL_GO,
    ST_DIVL_WAIT,
    ST_DIVV_GO,
    ST_DIVV_WAIT,
    ST_SQL,
    ST_SINL_GO,
    ST_SINL_WAIT,
    ST_SQV,
    ST_SINV_GO,
    ST_SINV_WAIT,
    ST_BASE_A,
    ST_BASE_B,
    ST_BASE_C,
    ST_POW_MUL,
    ST_POW_ACC,
    ST_COL_A,
    ST_COL_B,
    ST_COL_C,
    ST_COL_D,
    ST_FINISH
  } state_e;

  // pick one 16-bit lane of a packed three-lane word
  function automatic logic [LaneW-1:0] lane_sel(input logic [VecW-1:0] w,
                                                input logic [1:0] k);
    logic [LaneW-1:0] r;
    case (k)
      2'd0:    r = w[LaneW-1:0];
      2'd1:    r = w[2*LaneW-1:LaneW];
      default: r = w[3*LaneW-1:2*LaneW];
    endcase
    return r;
  endfunction

endpackage

>>> rtl/kkh_mul.sv
module kkh_mul (
  input  logic                               clk_i,
  input  logic signed [kkh_pkg::MulAW-1:0]   a_i,
  input  logic signed [kkh_pkg::MulBW-1:0]   b_i,
  output logic signed [kkh_pkg::MulPW-1:0]   p_o
);

  // registered signed product, one result per cycle
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

>>> rtl/kkh_sqrt.sv
module kkh_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kkh_pkg::RootArgW-1:0]  arg_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [kkh_pkg::RootW-1:0]     root_o
);

  localparam int unsigned RemW = kkh_pkg::RootW + 4;
  localparam int unsigned CntW = $clog2(kkh_pkg::RootW);

  logic [kkh_pkg::RootArgW-1:0] x_q;
  logic [RemW-1:0]              rem_q;
  logic [kkh_pkg::RootW-1:0]    root_q;
  logic [CntW-1:0]              cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [RemW-1:0]              rem_sh;
  logic [RemW-1:0]              trial;
  logic                         ge;

  // one root bit per cycle, two argument bits shifted in
  assign rem_sh = {rem_q[RemW-3:0], x_q[kkh_pkg::RootArgW-1 -: 2]};
  assign trial  = {{(RemW-kkh_pkg::RootW-2){1'b0}}, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(kkh_pkg::RootW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= arg_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[kkh_pkg::RootArgW-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[kkh_pkg::RootW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/kkh_div.sv
module kkh_div #(
  parameter int unsigned NumW = 51
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NumW-1:0]             num_i,
  input  logic [kkh_pkg::RootW-1:0]   den_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [kkh_pkg::QuotW-1:0]   quot_o
);

  localparam int unsigned MinW = kkh_pkg::RootW + kkh_pkg::QuotW + 1;
  localparam int unsigned IntW = (NumW > MinW) ? NumW : MinW;
  localparam int unsigned CntW = $clog2(kkh_pkg::QuotW);

  logic [IntW-1:0]           r_q;
  logic [IntW-1:0]           d_q;
  logic [kkh_pkg::QuotW-1:0] q_q;
  logic                      sat_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic                      ge;

  assign ge = r_q >= d_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(kkh_pkg::QuotW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle; a quotient past the
  // top bit is flagged at start and clamps
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= IntW'(num_i);
      d_q   <= IntW'(den_i) << (kkh_pkg::QuotW - 1);
      sat_q <= IntW'(num_i) >= (IntW'(den_i) << kkh_pkg::QuotW);
      q_q   <= '0;
    end else if (busy_q) begin
      r_q <= ge ? r_q - d_q : r_q;
      d_q <= d_q >> 1;
      q_q <= {q_q[kkh_pkg::QuotW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = (sat_q || (q_q > kkh_pkg::OneQ16)) ? kkh_pkg::OneQ16 : q_q;

endmodule

>>> rtl/kajiya_kay_hair_shading.sv
// channel    dir  bits  contents
// s_axis     in   240   tangent, light dir, view dir, light color, surface color
//                       tlast: last light sample of the shading point
// m_axis     out  64    red, green, blue Q8.12, once per shading point
//
// each sample runs three 32-step roots on one root unit and two 17-step
// divides on one divider before the next is accepted; a zero tangent
// skips the length root and both divides.
// all products go through one registered 34x18 multiplier.
// s_axis_tready is high only while idle; a finished color waits in the
// output register and only a second color held back by a stalled m_axis
// stops the sequencer. reset clears the accumulators.
module kajiya_kay_hair_shading #(
  parameter int unsigned VECTOR_FRACTION_BITS = kkh_pkg::VecFracBits,
  parameter int unsigned SPECULAR_EXPONENT    = kkh_pkg::SpecExp
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tangent_raw, light_direction, view_direction, light_color, surface_color
  input  logic [kkh_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // shade_red, shade_green, shade_blue, zero fill
  output logic [kkh_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int unsigned NumShift = 2 * kkh_pkg::RootW - 2 * VECTOR_FRACTION_BITS
                                     + VECTOR_FRACTION_BITS - kkh_pkg::RootW;
  localparam int unsigned NumW     = kkh_pkg::RootW + NumShift + 1;
  localparam int unsigned VecW     = kkh_pkg::VecW;
  localparam int unsigned LaneW    = kkh_pkg::LaneW;
  localparam int unsigned ChanW    = kkh_pkg::ChanW;
  localparam int unsigned MulAW    = kkh_pkg::MulAW;
  localparam int unsigned MulBW    = kkh_pkg::MulBW;

  kkh_pkg::state_e state_q, state_d;

  logic [kkh_pkg::InDataW-1:0] in_q, in_d;
  logic                        last_q, last_d;
  logic [1:0]                  lane_q, lane_d;
  logic [1:0]                  op_q, op_d;
  logic [31:0]                 len2_q, len2_d;
  logic signed [33:0]          dl_q, dl_d, dv_q, dv_d;
  logic [kkh_pkg::RootW-1:0]   lenq_q, lenq_d;
  logic signed [17:0]          tl_q, tl_d, ti_q, ti_d;
  logic [16:0]                 diff_q, diff_d, sti_q, sti_d;
  logic signed [34:0]          prod_q, prod_d;
  logic [16:0]                 base_q, base_d, spec_q, spec_d;
  logic [32:0]                 mix_q, mix_d;
  logic [kkh_pkg::ExpCntW-1:0] ecnt_q, ecnt_d;
  logic [ChanW-1:0]            acc_q [3];
  logic [ChanW-1:0]            acc_d [3];
  logic [3*ChanW-1:0]          out_q, out_d;
  logic                        oval_q, oval_d;

  logic signed [MulAW-1:0]          mul_a;
  logic signed [MulBW-1:0]          mul_b;
  logic signed [kkh_pkg::MulPW-1:0] mul_p;

  logic                           sq_start, sq_busy, sq_done;
  logic [kkh_pkg::RootArgW-1:0]   sq_arg;
  logic [kkh_pkg::RootW-1:0]      sq_root;
  logic                           dv_start, dv_busy, dv_done;
  logic [NumW-1:0]                dv_num;
  logic [kkh_pkg::QuotW-1:0]      dv_quot;

  logic [LaneW-1:0]   t_lane, l_lane, v_lane, cd_lane, cl_lane;
  logic signed [33:0] dot_sel, dot_mag;
  logic signed [33:0] sin_arg;
  logic signed [35:0] base_sum, base_rnd;
  logic [21:0]        term;
  logic [22:0]        acc_sum;
  logic [ChanW:0]     out_r, out_g, out_b;

  // shared units
  kkh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  kkh_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  kkh_div #(.NumW(NumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (lenq_q),
    .busy_o  (dv_busy),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  // lane picks from the held transaction
  assign t_lane  = kkh_pkg::lane_sel(in_q[VecW-1:0], lane_q);
  assign l_lane  = kkh_pkg::lane_sel(in_q[2*VecW-1:VecW], lane_q);
  assign v_lane  = kkh_pkg::lane_sel(in_q[3*VecW-1:2*VecW], lane_q);
  assign cl_lane = kkh_pkg::lane_sel(in_q[4*VecW-1:3*VecW], lane_q);
  assign cd_lane = kkh_pkg::lane_sel(in_q[5*VecW-1:4*VecW], lane_q);

  // divide numerator: |dot| scaled to Q16 plus half the length for rounding
  assign dot_sel = (state_q == kkh_pkg::ST_DIVL_GO) ? dl_q : dv_q;
  assign dot_mag = dot_sel[33] ? -dot_sel : dot_sel;
  assign dv_num  = (NumW'(dot_mag[31:0]) << NumShift) + NumW'(lenq_q >> 1);

  // 1 - c^2 in Q32, clamped at zero
  assign sin_arg = 34'sh1_0000_0000 - mul_p[33:0];

  // specular base: sine product plus cosine product, rounded to Q16
  assign base_sum = {prod_q[34], prod_q} + {mul_p[34], mul_p[34:0]};
  assign base_rnd = (base_sum[35] ? 36'sd0 : base_sum) + 36'sd32768;

  // per-channel term rounded to Q12 and saturating accumulate
  assign term    = 22'((mul_p[48:0] + 49'd134217728) >> 28);
  assign acc_sum = 23'(acc_q[lane_q]) + 23'(term);

  // final color plus ambient
  assign out_r = {1'b0, acc_q[0]} + {1'b0, kkh_pkg::AmbRed};
  assign out_g = {1'b0, acc_q[1]} + {1'b0, kkh_pkg::AmbGreen};
  assign out_b = {1'b0, acc_q[2]} + {1'b0, kkh_pkg::AmbBlue};

  // sequencer: next state, unit controls and datapath updates
  always_comb begin
    state_d  = state_q;
    in_d     = in_q;
    last_d   = last_q;
    lane_d   = lane_q;
    op_d     = op_q;
    len2_d   = len2_q;
    dl_d     = dl_q;
    dv_d     = dv_q;
    lenq_d   = lenq_q;
    tl_d     = tl_q;
    ti_d     = ti_q;
    diff_d   = diff_q;
    sti_d    = sti_q;
    prod_d   = prod_q;
    base_d   = base_q;
    spec_d   = spec_q;
    mix_d    = mix_q;
    ecnt_d   = ecnt_q;
    acc_d    = acc_q;
    out_d    = out_q;
    oval_d   = oval_q && !m_axis_tready;
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    sq_arg   = '0;
    dv_start = 1'b0;
    case (state_q)
      kkh_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_d    = s_axis_tdata;
          last_d  = s_axis_tlast;
          lane_d  = '0;
          op_d    = kkh_pkg::OpLen;
          len2_d  = '0;
          dl_d    = '0;
          dv_d    = '0;
          state_d = kkh_pkg::ST_DOT_MUL;
        end
      end
      kkh_pkg::ST_DOT_MUL: begin
        mul_a = {{(MulAW-LaneW){t_lane[LaneW-1]}}, t_lane};
        case (op_q)
          kkh_pkg::OpLen:  mul_b = {{(MulBW-LaneW){t_lane[LaneW-1]}}, t_lane};
          kkh_pkg::OpDotL: mul_b = {{(MulBW-LaneW){l_lane[LaneW-1]}}, l_lane};
          default:         mul_b = {{(MulBW-LaneW){v_lane[LaneW-1]}}, v_lane};
        endcase
        state_d = kkh_pkg::ST_DOT_ACC;
      end
      kkh_pkg::ST_DOT_ACC: begin
        case (op_q)
          kkh_pkg::OpLen:  len2_d = len2_q + mul_p[31:0];
          kkh_pkg::OpDotL: dl_d = dl_q + mul_p[33:0];
          default:         dv_d = dv_q + mul_p[33:0];
        endcase
        state_d = kkh_pkg::ST_DOT_MUL;
        if (op_q == kkh_pkg::OpDotV) begin
          op_d = kkh_pkg::OpLen;
          if (lane_q == kkh_pkg::LaneLast) begin
            state_d = kkh_pkg::ST_LEN_GO;
          end else begin
            lane_d = lane_q + 2'd1;
          end
        end else begin
          op_d = op_q + 2'd1;
        end
      end
      kkh_pkg::ST_LEN_GO: begin
        if (len2_q == '0) begin
          tl_d    = '0;
          ti_d    = '0;
          state_d = kkh_pkg::ST_SQL;
        end else begin
          sq_start = 1'b1;
          sq_arg   = {len2_q, 32'd0};
          state_d  = kkh_pkg::ST_LEN_WAIT;
        end
      end
      kkh_pkg::ST_LEN_WAIT: begin
        if (sq_done) begin
          lenq_d  = sq_root;
          state_d = kkh_pkg::ST_DIVL_GO;
        end
      end
      kkh_pkg::ST_DIVL_GO: begin
        dv_start = 1'b1;
        state_d  = kkh_pkg::ST_DIVL_WAIT;
      end
      kkh_pkg::ST_DIVL_WAIT: begin
        if (dv_done) begin
          tl_d    = dl_q[33] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
          state_d = kkh_pkg::ST_DIVV_GO;
        end
      end
      kkh_pkg::ST_DIVV_GO: begin
        dv_start = 1'b1;
        state_d  = kkh_pkg::ST_DIVV_WAIT;
      end
      kkh_pkg::ST_DIVV_WAIT: begin
        if (dv_done) begin
          ti_d    = dv_q[33] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
          state_d = kkh_pkg::ST_SQL;
        end
      end
      kkh_pkg::ST_SQL: begin
        mul_a   = {{(MulAW-18){tl_q[17]}}, tl_q};
        mul_b   = tl_q;
        state_d = kkh_pkg::ST_SINL_GO;
      end
      kkh_pkg::ST_SINL_GO: begin
        sq_start = 1'b1;
        sq_arg   = sin_arg[33] ? '0 : {30'd0, sin_arg};
        state_d  = kkh_pkg::ST_SINL_WAIT;
      end
      kkh_pkg::ST_SINL_WAIT: begin
        if (sq_done) begin
          diff_d  = sq_root[16:0];
          state_d = kkh_pkg::ST_SQV;
        end
      end
      kkh_pkg::ST_SQV: begin
        mul_a   = {{(MulAW-18){ti_q[17]}}, ti_q};
        mul_b   = ti_q;
        state_d = kkh_pkg::ST_SINV_GO;
      end
      kkh_pkg::ST_SINV_GO: begin
        sq_start = 1'b1;
        sq_arg   = sin_arg[33] ? '0 : {30'd0, sin_arg};
        state_d  = kkh_pkg::ST_SINV_WAIT;
      end
      kkh_pkg::ST_SINV_WAIT: begin
        if (sq_done) begin
          sti_d   = sq_root[16:0];
          state_d = kkh_pkg::ST_BASE_A;
        end
      end
      kkh_pkg::ST_BASE_A: begin
        mul_a   = {{(MulAW-17){1'b0}}, diff_q};
        mul_b   = {1'b0, sti_q};
        state_d = kkh_pkg::ST_BASE_B;
      end
      kkh_pkg::ST_BASE_B: begin
        prod_d  = mul_p[34:0];
        mul_a   = {{(MulAW-18){tl_q[17]}}, tl_q};
        mul_b   = ti_q;
        state_d = kkh_pkg::ST_BASE_C;
      end
      kkh_pkg::ST_BASE_C: begin
        base_d  = ((base_rnd >>> 16) > 36'sd65536) ? kkh_pkg::OneQ16
                                                    : base_rnd[32:16];
        spec_d  = kkh_pkg::OneQ16;
        ecnt_d  = '0;
        state_d = kkh_pkg::ST_POW_MUL;
      end
      kkh_pkg::ST_POW_MUL: begin
        mul_a   = {{(MulAW-17){1'b0}}, spec_q};
        mul_b   = {1'b0, base_q};
        state_d = kkh_pkg::ST_POW_ACC;
      end
      kkh_pkg::ST_POW_ACC: begin
        spec_d = 17'((mul_p[33:0] + 34'd32768) >> 16);
        if (ecnt_q == kkh_pkg::ExpCntW'(SPECULAR_EXPONENT - 1)) begin
          lane_d  = '0;
          state_d = kkh_pkg::ST_COL_A;
        end else begin
          ecnt_d  = ecnt_q + 1'b1;
          state_d = kkh_pkg::ST_POW_MUL;
        end
      end
      kkh_pkg::ST_COL_A: begin
        mul_a   = {{(MulAW-LaneW){1'b0}}, cd_lane};
        mul_b   = {1'b0, diff_q};
        state_d = kkh_pkg::ST_COL_B;
      end
      kkh_pkg::ST_COL_B: begin
        mix_d   = mul_p[32:0] + (33'(spec_q) << 12);
        state_d = kkh_pkg::ST_COL_C;
      end
      kkh_pkg::ST_COL_C: begin
        mul_a   = {1'b0, mix_q};
        mul_b   = {{(MulBW-LaneW){1'b0}}, cl_lane};
        state_d = kkh_pkg::ST_COL_D;
      end
      kkh_pkg::ST_COL_D: begin
        acc_d[lane_q] = (acc_sum > 23'(kkh_pkg::ChanMax)) ? kkh_pkg::ChanMax
                                                           : acc_sum[ChanW-1:0];
        if (lane_q == kkh_pkg::LaneLast) begin
          state_d = kkh_pkg::ST_FINISH;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = kkh_pkg::ST_COL_A;
        end
      end
      kkh_pkg::ST_FINISH: begin
        if (!last_q) begin
          state_d = kkh_pkg::ST_IDLE;
        end else if (!oval_q || m_axis_tready) begin
          out_d[ChanW-1:0]       = out_r[ChanW] ? kkh_pkg::ChanMax : out_r[ChanW-1:0];
          out_d[2*ChanW-1:ChanW] = out_g[ChanW] ? kkh_pkg::ChanMax : out_g[ChanW-1:0];
          out_d[3*ChanW-1:2*ChanW] = out_b[ChanW] ? kkh_pkg::ChanMax
                                                  : out_b[ChanW-1:0];
          oval_d  = 1'b1;
          acc_d   = '{default: '0};
          state_d = kkh_pkg::ST_IDLE;
        end
      end
      default: state_d = kkh_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kkh_pkg::ST_IDLE;
      oval_q  <= 1'b0;
      acc_q   <= '{default: '0};
      lane_q  <= '0;
      op_q    <= '0;
      ecnt_q  <= '0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
      acc_q   <= acc_d;
      lane_q  <= lane_d;
      op_q    <= op_d;
      ecnt_q  <= ecnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    last_q <= last_d;
    len2_q <= len2_d;
    dl_q   <= dl_d;
    dv_q   <= dv_d;
    lenq_q <= lenq_d;
    tl_q   <= tl_d;
    ti_q   <= ti_d;
    diff_q <= diff_d;
    sti_q  <= sti_d;
    prod_q <= prod_d;
    base_q <= base_d;
    spec_q <= spec_d;
    mix_q  <= mix_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = (state_q == kkh_pkg::ST_IDLE);
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {{(kkh_pkg::OutDataW-3*ChanW){1'b0}}, out_q};

`ifndef ASSERT_OFF
  // neither the root unit nor the divider still runs while a new transaction can enter
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sq_busy && !dv_busy)
    else $error("root or divide unit busy while idle");

  // power stays within one in Q16
  a_pow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kkh_pkg::ST_POW_MUL) |-> (spec_q <= kkh_pkg::OneQ16) &&
                                         (base_q <= kkh_pkg::OneQ16))
    else $error("specular value out of range");

  // a sample that is not last never raises a color
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kkh_pkg::ST_FINISH) && !last_q |=> !$rose(m_axis_tvalid))
    else $error("color emitted on a sample not marked last");
`endif

endmodule

>>> dv/kajiya_kay_hair_shading_tb.sv
`timescale 1ns / 1ps

module kajiya_kay_hair_shading_tb;

  localparam int unsigned VFB = 14;
  localparam int unsigned SEXP = 20;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [kkh_pkg::VecW-1:0] surface_color;
    logic [kkh_pkg::VecW-1:0] light_color;
    logic [kkh_pkg::VecW-1:0] view_dir;
    logic [kkh_pkg::VecW-1:0] light_dir;
    logic [kkh_pkg::VecW-1:0] tangent;
  } sample_t;

  typedef struct {
    sample_t s;
    logic    last;
  } light_txn_t;

  typedef struct {
    logic [kkh_pkg::ChanW-1:0] red;
    logic [kkh_pkg::ChanW-1:0] green;
    logic [kkh_pkg::ChanW-1:0] blue;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [kkh_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [kkh_pkg::OutDataW-1:0] m_axis_tdata;

  kajiya_kay_hair_shading dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  light_txn_t pending_q[$];
  color_t     shade_q[$];
  logic [kkh_pkg::ChanW-1:0] acc_r, acc_g, acc_b;
  int  errors = 0;
  longint cycles = 0;
  bit  hold_sink = 1'b0;
  bit  sender_pause = 1'b0;
  int  src_gap = 0;
  int  snk_gap = 0;

  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint signed_lane(logic [kkh_pkg::VecW-1:0] w, int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  function automatic longint to_unit(longint d, longint unsigned len_q);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = ((mag << (32 - VFB)) + (len_q >> 1)) / len_q;
    if (q > 65536) q = 65536;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned sine_of(longint c);
    longint a;
    a = (64'sd1 <<< 32) - c * c;
    if (a < 0) a = 0;
    return isqrt(a);
  endfunction

  function automatic logic [kkh_pkg::ChanW-1:0] add_sat(logic [kkh_pkg::ChanW-1:0] a,
                                                        longint unsigned b);
    longint unsigned s;
    s = a + b;
    return s > 1048575 ? kkh_pkg::ChanMax : s[kkh_pkg::ChanW-1:0];
  endfunction

  // shading predictor: adds one sample into the accumulators and queues the color on a last sample
  task automatic shade_sample(input light_txn_t t);
    longint tv, dl, dv, tl, ti, base;
    longint unsigned len2, len_q, diff, sti, spec, mix, cd, cl;
    longint unsigned term[3];
    color_t c;
    dl = 0; dv = 0; len2 = 0; tl = 0; ti = 0;
    for (int k = 0; k < 3; k++) begin
      tv = signed_lane(t.s.tangent, k);
      len2 += tv * tv;
      dl += tv * signed_lane(t.s.light_dir, k);
      dv += tv * signed_lane(t.s.view_dir, k);
    end
    if (len2 != 0) begin
      len_q = isqrt(len2 << 32);
      tl = to_unit(dl, len_q);
      ti = to_unit(dv, len_q);
    end
    diff = sine_of(tl);
    sti = sine_of(ti);
    base = longint'(diff * sti) + tl * ti;
    if (base < 0) base = 0;
    base = (base + 32768) >>> 16;
    if (base > 65536) base = 65536;
    spec = 65536;
    for (int e = 0; e < SEXP; e++) spec = (spec * longint'(base) + 32768) >> 16;
    for (int k = 0; k < 3; k++) begin
      cd = t.s.surface_color[16*k +: 16];
      cl = t.s.light_color[16*k +: 16];
      mix = cd * diff + (spec << 12);
      term[k] = (mix * cl + (64'd1 << 27)) >> 28;
    end
    acc_r = add_sat(acc_r, term[0]);
    acc_g = add_sat(acc_g, term[1]);
    acc_b = add_sat(acc_b, term[2]);
    if (t.last) begin
      c.red = add_sat(acc_r, kkh_pkg::AmbRed);
      c.green = add_sat(acc_g, kkh_pkg::AmbGreen);
      c.blue = add_sat(acc_b, kkh_pkg::AmbBlue);
      shade_q.push_back(c);
      acc_r = '0; acc_g = '0; acc_b = '0;
    end
  endtask

  // driver: offers queued samples with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        shade_sample(pending_q.pop_front());
        src_gap <= rand_gap();
        if (pending_q.size() == 0 || rand_gap() != 0 || sender_pause) s_axis_tvalid <= 1'b0;
        else begin
          s_axis_tdata <= pending_q[0].s;
          s_axis_tlast <= pending_q[0].last;
        end
      end else if (!s_axis_tvalid) begin
        if (src_gap > 0) src_gap <= src_gap - 1;
        else if (pending_q.size() > 0 && !sender_pause) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_q[0].s;
          s_axis_tlast <= pending_q[0].last;
        end
      end
    end
  end

  // monitor: compares each color transaction with the oldest prediction
  always @(posedge clk_i) begin
    color_t e;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (shade_q.size() == 0) begin
          $error("unexpected color transaction %h", m_axis_tdata);
          errors++;
        end else begin
          e = shade_q.pop_front();
          if (m_axis_tdata[19:0] !== e.red) begin
            $error("shade_red exp %h got %h", e.red, m_axis_tdata[19:0]); errors++;
          end
          if (m_axis_tdata[39:20] !== e.green) begin
            $error("shade_green exp %h got %h", e.green, m_axis_tdata[39:20]); errors++;
          end
          if (m_axis_tdata[59:40] !== e.blue) begin
            $error("shade_blue exp %h got %h", e.blue, m_axis_tdata[59:40]); errors++;
          end
        end
      end
      if (hold_sink) m_axis_tready <= 1'b0;
      else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) snk_gap <= rand_gap();
      end
    end
  end

  // long receiver hold-off, counted in its own process
  initial begin
    int n;
    n = 0;
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_sink = 1'b1;
    while (n < 4000) begin
      @(posedge clk_i);
      n++;
    end
    hold_sink = 1'b0;
  end

  // timeout
  initial begin
    wait (cycles >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [kkh_pkg::VecW-1:0] rand_vec();
    return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535))};
  endfunction

  // random unit-ish direction with a few exact axes
  function automatic logic [kkh_pkg::VecW-1:0] rand_dir();
    logic [15:0] l[3];
    int ax;
    if ($urandom_range(0, 3) == 0) begin
      ax = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) l[k] = 16'd0;
      l[ax] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
    end else begin
      for (int k = 0; k < 3; k++) l[k] = 16'($signed($urandom_range(0, 18918)) - 9459);
    end
    return {l[2], l[1], l[0]};
  endfunction

  task automatic queue_sample(input logic [kkh_pkg::VecW-1:0] t, ld, vd, lc, sc,
                              input logic last);
    light_txn_t x;
    x.s.tangent = t; x.s.light_dir = ld; x.s.view_dir = vd;
    x.s.light_color = lc; x.s.surface_color = sc; x.last = last;
    pending_q.push_back(x);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || shade_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  localparam logic [kkh_pkg::VecW-1:0] X1 = 48'h0000_0000_4000;
  localparam logic [kkh_pkg::VecW-1:0] Y1 = 48'h0000_4000_0000;
  localparam logic [kkh_pkg::VecW-1:0] NX1 = 48'h0000_0000_c000;
  localparam logic [kkh_pkg::VecW-1:0] W1 = 48'h1000_1000_1000;

  initial begin
    int n_items;
    acc_r = '0; acc_g = '0; acc_b = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed samples
    queue_sample('0, X1, Y1, W1, W1, 1'b1);
    queue_sample(X1, X1, X1, W1, W1, 1'b1);
    queue_sample(X1, NX1, X1, W1, W1, 1'b1);
    queue_sample(X1, Y1, NX1, W1, W1, 1'b1);
    queue_sample(48'h7fff_7fff_7fff, '1, '1, '1, '1, 1'b1);
    queue_sample(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7fff_7fff_7fff, '1, '0, 1'b1);
    queue_sample(48'h0000_0000_0001, X1, X1, W1, W1, 1'b1);
    queue_sample(X1, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, W1, W1, 1'b1);
    for (int i = 0; i < 8; i++) queue_sample('0, X1, X1, '1, '1, i == 7);
    queue_sample(X1, Y1, Y1, '0, '0, 1'b0);
    queue_sample(X1, Y1, Y1, '0, '0, 1'b1);
    drain();
    // sender holds back one queued sample, then resumes
    sender_pause = 1'b1;
    queue_sample(rand_vec(), rand_dir(), rand_dir(), rand_vec(), rand_vec(), 1'b1);
    repeat (50) @(posedge clk_i);
    sender_pause = 1'b0;
    drain();
    // random shading points
    n_items = 0;
    while (n_items < 850) begin
      int len;
      len = $urandom_range(0, 9) == 0 ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        logic [kkh_pkg::VecW-1:0] t, lc, sc;
        t = $urandom_range(0, 19) == 0 ? '0 : rand_vec();
        lc = $urandom_range(0, 4) == 0 ? rand_vec() : {3{16'($urandom_range(0, 4096))}};
        sc = $urandom_range(0, 4) == 0 ? rand_vec() : rand_vec() & 48'h0fff_0fff_0fff;
        if ($urandom_range(0, 9) == 0)
          queue_sample(t, rand_vec(), rand_vec(), lc, sc, i == len - 1);
        else
          queue_sample(t, rand_dir(), rand_dir(), lc, sc, i == len - 1);
        n_items++;
      end
      while (pending_q.size() > 20) @(posedge clk_i);
    end
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
